/* sv/ped_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ped_pkg;

   localparam int MAX_VERTICES    = 1024;
   localparam int ADDR_W          = $clog2(MAX_VERTICES);
   localparam int CNT_W           = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W         = 32;
   localparam int DIFF_W          = COORD_W + 1;
   localparam int THR_W           = 31;
   localparam int ANGLE_W         = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_STEPS    = 31;
   localparam int STEP_W          = $clog2(CORDIC_STEPS + 1);
   localparam int PRE_SHIFT       = 20;
   // headroom for the CORDIC gain on a 33 bit offset scaled by 2^20
   localparam int XY_W            = DIFF_W + PRE_SHIFT + 3;
   localparam int Z_W             = 35;
   localparam int RND_SHIFT       = 30 - ANGLE_FRAC_BITS;

   localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [Z_W-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [Z_W-1:0] RND_HALF    = Z_W'(64'sd1 <<< (RND_SHIFT - 1));
   localparam logic signed [Z_W-1:0] ANGLE_LIM   = (PI_Q30 + RND_HALF) >>> RND_SHIFT;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x_coord;
      coord_type y_coord;
      logic      last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] begin_angle;
      logic signed [ANGLE_W-1:0] end_angle;
      logic                      degenerate;
      logic                      single_point;
      logic                      overflowed;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } cordic_cmd_type;

   typedef struct packed {
      logic                      done;
      logic signed [ANGLE_W-1:0] angle;
   } cordic_res_type;

   // atan(2^-i) in Q30
   function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] step);
      logic [29:0] v;
      begin
         case (step)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            5'd24:   v = 30'd64;
            5'd25:   v = 30'd32;
            5'd26:   v = 30'd16;
            5'd27:   v = 30'd8;
            5'd28:   v = 30'd4;
            5'd29:   v = 30'd2;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

/* sv/ped_point_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module ped_point_store (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [ped_pkg::ADDR_W-1:0] wr_addr,
   input  wire ped_pkg::point_type         wr_data,
   input  wire logic                       rd_en,
   input  wire logic [ped_pkg::ADDR_W-1:0] rd_addr,
   output ped_pkg::point_type              rd_data
);
   import ped_pkg::*;

   point_type mem [MAX_VERTICES];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/ped_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

module ped_cordic (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ped_pkg::cordic_cmd_type cmd,
   output ped_pkg::cordic_res_type      res
);
   import ped_pkg::*;

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_ROT  = 2'd1;
   localparam logic [1:0] C_ITER = 2'd2;
   localparam logic [1:0] C_DONE = 2'd3;

   logic [1:0]                st_ff, st_in;
   logic signed [DIFF_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [XY_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]     z_ff, z_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      done_ff, done_in;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;

   logic signed [XY_W-1:0]    x_sc, y_sc, x_sh, y_sh;
   logic signed [Z_W-1:0]     step_atan, z_rnd, z_clamp;

   always_comb begin
      st_in    = st_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      angle_in = angle_ff;

      x_sc      = XY_W'(dx_ff) <<< PRE_SHIFT;
      y_sc      = XY_W'(dy_ff) <<< PRE_SHIFT;
      x_sh      = x_ff >>> step_ff;
      y_sh      = y_ff >>> step_ff;
      step_atan = Z_W'(atan_q30(step_ff));
      z_rnd     = (z_ff + RND_HALF) >>> RND_SHIFT;

      if (z_rnd > ANGLE_LIM) begin
         z_clamp = ANGLE_LIM;
      end else if (z_rnd < -ANGLE_LIM) begin
         z_clamp = -ANGLE_LIM;
      end else begin
         z_clamp = z_rnd;
      end

      case (st_ff)
         C_IDLE: begin
            if (cmd.start) begin
               dx_in = cmd.dx;
               dy_in = cmd.dy;
               st_in = C_ROT;
            end
         end
         C_ROT: begin
            step_in = '0;
            if (dx_ff == '0 && dy_ff == '0) begin
               z_in  = '0;
               st_in = C_DONE;
            end else if (dx_ff < 0) begin
               // left half plane: turn by a quarter and preload the angle
               if (dy_ff >= 0) begin
                  x_in = y_sc;
                  y_in = -x_sc;
                  z_in = HALF_PI_Q30;
               end else begin
                  x_in = -y_sc;
                  y_in = x_sc;
                  z_in = -HALF_PI_Q30;
               end
               st_in = C_ITER;
            end else begin
               x_in  = x_sc;
               y_in  = y_sc;
               z_in  = '0;
               st_in = C_ITER;
            end
         end
         C_ITER: begin
            if (y_ff == '0 || step_ff == STEP_W'(CORDIC_STEPS)) begin
               st_in = C_DONE;
            end else begin
               if (y_ff > 0) begin
                  x_in = x_ff + y_sh;
                  y_in = y_ff - x_sh;
                  z_in = z_ff + step_atan;
               end else begin
                  x_in = x_ff - y_sh;
                  y_in = y_ff + x_sh;
                  z_in = z_ff - step_atan;
               end
               step_in = step_ff + STEP_W'(1);
            end
         end
         C_DONE: begin
            done_in  = 1'b1;
            angle_in = z_clamp[ANGLE_W-1:0];
            st_in    = C_IDLE;
         end
         default: begin
            st_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= C_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      step_ff  <= step_in;
      angle_ff <= angle_in;
   end

   assign res = {done_ff, angle_ff};

endmodule

`default_nettype wire

/* sv/polyline_end_direction_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Polyline end direction unit. Vertices are taken one per cycle while busy is low;
// a vertex without the last flag gives no result. The closing vertex of a line of
// two or more stored vertices raises busy for the length of two passes of the
// shared CORDIC, each of up to 31 steps plus load, turn and round; for a line of
// three or more it also runs two searches over the point store's single read port.
// The result is shown on rsp_data for one cycle with rsp_valid; it cannot be
// held off, so it must be captured in that cycle. A one-vertex line gives its
// result in the cycle after it is taken. The threshold register is always ready
// and should be written only while the block is idle.

module polyline_end_direction_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire ped_pkg::req_type          req_data,
   output logic                           rsp_valid,
   output ped_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [ped_pkg::THR_W-1:0] csr_wdata
);
   import ped_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_SRCH = 3'd2;
   localparam logic [2:0] S_CORD = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;

   function automatic logic far_apart(input point_type a, input point_type b,
                                      input logic [THR_W-1:0] thr);
      logic signed [DIFF_W-1:0] dx, dy;
      logic [DIFF_W-1:0]        ax, ay;
      begin
         dx = DIFF_W'(a.x) - DIFF_W'(b.x);
         dy = DIFF_W'(a.y) - DIFF_W'(b.y);
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         return (ax > DIFF_W'(thr)) || (ay > DIFF_W'(thr));
      end
   endfunction

   logic [2:0]                state_ff, state_in;
   logic [THR_W-1:0]          thr_ff, thr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      spread_ff, spread_in;
   logic                      ovf_seen_ff, ovf_seen_in;
   logic                      phase_ff, phase_in;
   logic                      issue_ff, issue_in;
   logic                      pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   point_type                 v0_ff, v0_in, v1_ff, v1_in;
   point_type                 last_ff, last_in, prev_ff, prev_in;
   point_type                 tgt_ff, tgt_in;
   logic                      many_ff, many_in;
   logic [ADDR_W-1:0]         nm2_ff, nm2_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic signed [ANGLE_W-1:0] beg_ff, beg_in;
   logic                      deg_ff, deg_in;
   logic                      ovf_ff, ovf_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      accept, store_en, spread_now, hit;
   logic [CNT_W-1:0]          count_inc;
   point_type                 in_pt, ref_pt, dflt_pt, rd_data;
   logic [ADDR_W-1:0]         stop_addr;
   logic                      rd_en;
   cordic_cmd_type            cor_cmd;
   cordic_res_type            cor_res;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign store_en   = accept && (count_ff < CNT_W'(MAX_VERTICES));
   assign count_inc  = count_ff + {{(CNT_W-1){1'b0}}, store_en};
   assign in_pt      = {req_data.x_coord, req_data.y_coord};
   assign spread_now = store_en && (count_ff != '0) && far_apart(in_pt, v0_ff, thr_ff);

   // begin pass searches from vertex 0, end pass from the last stored vertex
   assign ref_pt    = phase_ff ? last_ff : v0_ff;
   assign dflt_pt   = phase_ff ? prev_ff : v1_ff;
   assign stop_addr = phase_ff ? ADDR_W'(1) : nm2_ff;
   assign hit       = far_apart(rd_data, ref_pt, thr_ff);
   assign rd_en     = (state_ff == S_SRCH) && issue_ff;

   assign cor_cmd.start = (state_ff == S_CORD);
   assign cor_cmd.dx    = DIFF_W'(tgt_ff.x) - DIFF_W'(ref_pt.x);
   assign cor_cmd.dy    = DIFF_W'(tgt_ff.y) - DIFF_W'(ref_pt.y);

   ped_point_store u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (in_pt),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   ped_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cor_cmd),
      .res   (cor_res)
   );

   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      count_in     = count_ff;
      spread_in    = spread_ff;
      ovf_seen_in  = ovf_seen_ff;
      phase_in     = phase_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      tgt_in       = tgt_ff;
      many_in      = many_ff;
      nm2_in       = nm2_ff;
      addr_in      = addr_ff;
      beg_in       = beg_ff;
      deg_in       = deg_ff;
      ovf_in       = ovf_ff;
      rsp_in       = rsp_ff;

      if (csr_valid) begin
         thr_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (store_en) begin
               if (count_ff == '0) begin
                  v0_in = in_pt;
               end
               if (count_ff == CNT_W'(1)) begin
                  v1_in = in_pt;
               end
               prev_in   = last_ff;
               last_in   = in_pt;
               count_in  = count_inc;
               spread_in = spread_ff | spread_now;
            end else if (accept) begin
               ovf_seen_in = 1'b1;
            end
            if (accept && req_data.last_vertex) begin
               deg_in      = !(spread_ff | spread_now);
               ovf_in      = ovf_seen_ff | !store_en;
               count_in    = '0;
               spread_in   = 1'b0;
               ovf_seen_in = 1'b0;
               many_in     = (count_inc > CNT_W'(2));
               nm2_in      = ADDR_W'(count_inc - CNT_W'(2));
               phase_in    = 1'b0;
               if (count_inc <= CNT_W'(1)) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.begin_angle  = '0;
                  rsp_in.end_angle    = '0;
                  rsp_in.degenerate   = deg_in;
                  rsp_in.single_point = 1'b1;
                  rsp_in.overflowed   = ovf_in;
               end else begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            if (many_ff) begin
               addr_in  = ADDR_W'(1);
               issue_in = 1'b1;
               pend_in  = 1'b0;
               state_in = S_SRCH;
            end else begin
               tgt_in   = v1_ff;
               state_in = S_CORD;
            end
         end
         S_SRCH: begin
            // reads stream one a cycle, the compare follows in the cycle after each read
            if (issue_ff) begin
               addr_in = phase_ff ? (addr_ff - ADDR_W'(1)) : (addr_ff + ADDR_W'(1));
               if (addr_ff == stop_addr) begin
                  issue_in = 1'b0;
               end
            end
            pend_in = issue_ff;
            if (pend_ff) begin
               if (hit) begin
                  tgt_in   = rd_data;
                  state_in = S_CORD;
               end else if (!issue_ff) begin
                  tgt_in   = dflt_pt;
                  state_in = S_CORD;
               end
            end
         end
         S_CORD: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (cor_res.done) begin
               if (!phase_ff) begin
                  beg_in   = cor_res.angle;
                  phase_in = 1'b1;
                  if (many_ff) begin
                     addr_in  = nm2_ff;
                     issue_in = 1'b1;
                     pend_in  = 1'b0;
                     state_in = S_SRCH;
                  end else begin
                     tgt_in   = prev_ff;
                     state_in = S_CORD;
                  end
               end else begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.begin_angle  = beg_ff;
                  rsp_in.end_angle    = cor_res.angle;
                  rsp_in.degenerate   = deg_ff;
                  rsp_in.single_point = 1'b0;
                  rsp_in.overflowed   = ovf_ff;
                  state_in            = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= '0;
         count_ff     <= '0;
         spread_ff    <= 1'b0;
         ovf_seen_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         count_ff     <= count_in;
         spread_ff    <= spread_in;
         ovf_seen_ff  <= ovf_seen_in;
         phase_ff     <= phase_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v0_ff   <= v0_in;
      v1_ff   <= v1_in;
      last_ff <= last_in;
      prev_ff <= prev_in;
      tgt_ff  <= tgt_in;
      many_ff <= many_in;
      nm2_ff  <= nm2_in;
      addr_ff <= addr_in;
      beg_ff  <= beg_in;
      deg_ff  <= deg_in;
      ovf_ff  <= ovf_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

/* sv/ped_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ped_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire ped_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire ped_pkg::rsp_type rsp_data
);
   import ped_pkg::*;

   // a one-vertex line has no direction and counts as degenerate
   a_single_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.single_point |->
         rsp_data.begin_angle == '0 && rsp_data.end_angle == '0 && rsp_data.degenerate)
      else $error("single point item with nonzero angle or not degenerate");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.begin_angle <= ANGLE_LIM && rsp_data.begin_angle >= -ANGLE_LIM &&
         rsp_data.end_angle <= ANGLE_LIM && rsp_data.end_angle >= -ANGLE_LIM)
      else $error("angle outside +-pi");

   a_plain_no_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_data.last_vertex |=> !rsp_valid)
      else $error("result after an item without the last flag");

   // busy only drops when the line's result goes out
   a_busy_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

endmodule

bind polyline_end_direction_unit ped_checker u_ped_checker (.*);

`default_nettype wire

/* tb/sv/tb_polyline_end_direction_unit.sv */
`timescale 1ns / 1ps

module tb_polyline_end_direction_unit;
   import ped_pkg::*;

   localparam int          STORE_DEPTH = MAX_VERTICES;
   localparam int          RND_BITS    = 30 - ANGLE_FRAC_BITS;
   localparam longint      PI_Q30_TB   = 64'sd3373259426;
   localparam longint      HALF_PI_TB  = 64'sd1686629713;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          SMALL_ITEMS = 1700;
   localparam int          CALM_FROM   = 1450;
   localparam logic [30:0] THR_MAX     = 31'h7FFF_FFFF;
   localparam coord_type   CMIN        = 32'sh8000_0000;
   localparam coord_type   CMAX        = 32'sh7FFF_FFFF;
   localparam rsp_type     SINGLE_RSP  = rsp_type'({16'sd0, 16'sd0, 3'b110});
   localparam rsp_type     COINCIDENT  = rsp_type'({16'sd0, 16'sd0, 3'b100});

   typedef struct {
      bit          set_thr;
      logic [30:0] thr;
      req_type     vtx;
      bit          typed;
      rsp_type     want;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [THR_W-1:0] csr_wdata;

   // predictor state
   logic [30:0] near_thr;
   coord_type   x_mem [STORE_DEPTH];
   coord_type   y_mem [STORE_DEPTH];
   int          vcount;
   bit          spread;
   bit          dropped;

   longint atan_step_q30 [31] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1
   };

   rsp_type      expected_directions [$];
   plan_row_type directed_plan [$];
   rsp_type      want;
   int           mismatch_count = 0;
   int           cycle_count = 0;

   polyline_end_direction_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit is_far(int a, int b);
      longint dx;
      longint dy;
      dx = longint'(x_mem[a]) - longint'(x_mem[b]);
      dy = longint'(y_mem[a]) - longint'(y_mem[b]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return dx > longint'(near_thr) || dy > longint'(near_thr);
   endfunction

   // vectoring CORDIC, result rounded to Q3.13 and clamped to +-pi
   function automatic logic signed [15:0] cordic_angle(longint dy, longint dx);
      longint x;
      longint y;
      longint z;
      longint t;
      longint sx;
      longint sy;
      longint r;
      longint lim;
      if (dx == 0 && dy == 0) return '0;
      x = dx * 64'sd1048576;
      y = dy * 64'sd1048576;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = HALF_PI_TB;
         end else begin
            x = -y;
            y = t;
            z = -HALF_PI_TB;
         end
      end
      for (int i = 0; i < 31 && y != 0; i++) begin
         sx = x >>> i;
         sy = y >>> i;
         if (y > 0) begin
            x = x + sy;
            y = y - sx;
            z = z + atan_step_q30[i];
         end else begin
            x = x - sy;
            y = y + sx;
            z = z - atan_step_q30[i];
         end
      end
      r   = (z + (64'sd1 <<< (RND_BITS - 1))) >>> RND_BITS;
      lim = (PI_Q30_TB + (64'sd1 <<< (RND_BITS - 1))) >>> RND_BITS;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
   endfunction

   function automatic logic signed [15:0] angle_to(int from, int to);
      return cordic_angle(longint'(y_mem[to]) - longint'(y_mem[from]),
                          longint'(x_mem[to]) - longint'(x_mem[from]));
   endfunction

   // store one vertex; on the closing vertex work out the line's directions
   function automatic bit take_vertex(input req_type v, output rsp_type r);
      int n;
      int k;
      int last;
      r = '0;
      if (vcount < STORE_DEPTH) begin
         x_mem[vcount] = v.x_coord;
         y_mem[vcount] = v.y_coord;
         if (vcount > 0 && is_far(vcount, 0)) spread = 1'b1;
         vcount++;
      end else begin
         dropped = 1'b1;
      end
      if (!v.last_vertex) return 1'b0;
      n = vcount;
      if (n <= 1) begin
         r.single_point = 1'b1;
      end else begin
         k = 1;
         for (int i = 1; i + 1 < n; i++) begin
            if (is_far(i, 0)) begin
               k = i;
               break;
            end
         end
         r.begin_angle = angle_to(0, k);
         last = n - 1;
         k    = n - 2;
         for (int i = n - 2; i > 0; i--) begin
            if (is_far(i, last)) begin
               k = i;
               break;
            end
         end
         r.end_angle = angle_to(last, k);
      end
      r.degenerate = !spread;
      r.overflowed = dropped;
      vcount  = 0;
      spread  = 1'b0;
      dropped = 1'b0;
      return 1'b1;
   endfunction

   task automatic send_vertex(input req_type v, input bit typed, input rsp_type typed_rsp);
      rsp_type r;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= v;
      do @(posedge clock); while (busy);
      if (take_vertex(v, r)) expected_directions.push_back(typed ? typed_rsp : r);
   endtask

   task automatic go_idle(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= req_type'({$urandom, $urandom, 1'($urandom)});
      end
   endtask

   task automatic write_threshold(input logic [30:0] val);
      @(negedge clock);
      start <= 1'b0;
      while (expected_directions.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      near_thr = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic plan_row_type row(bit set_thr, logic [30:0] thr, coord_type x,
                                        coord_type y, bit last, bit typed, rsp_type w);
      plan_row_type p;
      p.set_thr = set_thr;
      p.thr     = thr;
      p.vtx     = req_type'({x, y, last});
      p.typed   = typed;
      p.want    = w;
      return p;
   endfunction

   function automatic logic [30:0] pick_threshold(int phase);
      if (phase == 0) return '0;
      if (phase == 1) return THR_MAX;
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return THR_MAX;
         2:       return 31'($urandom_range(1, 64));
         3:       return 31'($urandom);
         default: return 31'(1) << $urandom_range(4, 30);
      endcase
   endfunction

   function automatic longint pick_offset(bit far_pick);
      longint mag;
      if (!far_pick)
         mag = ($urandom_range(0, 3) == 0) ? longint'(near_thr)
                                           : longint'($urandom_range(0, near_thr));
      else
         mag = longint'(near_thr) + (($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 5000));
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic coord_type extreme_coord();
      case ($urandom_range(0, 5))
         0:       return CMIN;
         1:       return CMAX;
         2:       return 32'sd0;
         3:       return -32'sd1;
         4:       return 32'sd1;
         default: return CMIN + 32'sd1;
      endcase
   endfunction

   // cluster lines sit around vertex 0 so the searches run deep
   task automatic send_line(input int len, input bit force_cluster, input bit idle_on);
      int        mode;
      int        far_odds;
      bit        far_pick;
      bit        on_x;
      coord_type bx;
      coord_type by;
      req_type   v;
      rsp_type   none;
      none     = '0;
      mode     = force_cluster ? 9 : $urandom_range(0, 9);
      far_odds = force_cluster ? 64 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 8));
      bx       = $urandom;
      by       = $urandom;
      for (int i = 0; i < len; i++) begin
         if (mode < 2) begin
            v.x_coord = $urandom;
            v.y_coord = $urandom;
         end else if (mode == 2) begin
            v.x_coord = extreme_coord();
            v.y_coord = extreme_coord();
         end else if (i == 0) begin
            v.x_coord = bx;
            v.y_coord = by;
         end else begin
            far_pick  = far_odds != 0 && $urandom_range(1, far_odds) == 1;
            on_x      = $urandom_range(0, 1);
            v.x_coord = bx + 32'(pick_offset(far_pick && on_x));
            v.y_coord = by + 32'(pick_offset(far_pick && !on_x));
         end
         v.last_vertex = (i == len - 1);
         send_vertex(v, 1'b0, none);
         if (idle_on && $urandom_range(0, 3) == 0) go_idle($urandom_range(1, 8));
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time,
                  expected_directions.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic compare_field(input string name, input logic signed [16:0] exp_v,
                                input logic signed [16:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_directions.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_directions.pop_front();
            compare_field("begin_angle", want.begin_angle, rsp_data.begin_angle);
            compare_field("end_angle", want.end_angle, rsp_data.end_angle);
            compare_field("degenerate", want.degenerate, rsp_data.degenerate);
            compare_field("single_point", want.single_point, rsp_data.single_point);
            compare_field("overflowed", want.overflowed, rsp_data.overflowed);
         end
      end
   end

   initial begin
      int           small_items;
      int           line_no;
      int           phase;
      int           len;
      bit           idle_on;
      bit           over_done;
      plan_row_type p;

      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_wdata      = '0;
      near_thr       = '0;
      vcount         = 0;
      spread         = 1'b0;
      dropped        = 1'b0;

      // threshold at its reset value for the first lines
      directed_plan.push_back(row(0, 0, 32'sd5, 32'sd7, 1, 1, SINGLE_RSP));
      directed_plan.push_back(row(0, 0, CMIN, CMAX, 1, 1, SINGLE_RSP));
      directed_plan.push_back(row(0, 0, 32'sd3, -32'sd3, 0, 0, '0));
      directed_plan.push_back(row(0, 0, 32'sd3, -32'sd3, 1, 1, COINCIDENT));
      directed_plan.push_back(row(0, 0, CMIN, CMIN, 0, 0, '0));
      directed_plan.push_back(row(0, 0, CMAX, CMAX, 1, 0, '0));
      directed_plan.push_back(row(0, 0, CMAX, CMIN, 0, 0, '0));
      directed_plan.push_back(row(0, 0, CMIN, CMAX, 1, 0, '0));
      // all four quadrants
      directed_plan.push_back(row(0, 0, 32'sd0, 32'sd0, 0, 0, '0));
      directed_plan.push_back(row(0, 0, 32'sd10, -32'sd10, 0, 0, '0));
      directed_plan.push_back(row(0, 0, -32'sd10, -32'sd10, 0, 0, '0));
      directed_plan.push_back(row(0, 0, -32'sd10, 32'sd10, 0, 0, '0));
      directed_plan.push_back(row(0, 0, 32'sd10, 32'sd10, 1, 0, '0));
      // along the axes
      directed_plan.push_back(row(0, 0, 32'sd0, 32'sd0, 0, 0, '0));
      directed_plan.push_back(row(0, 0, 32'sd0, -32'sd1000, 0, 0, '0));
      directed_plan.push_back(row(0, 0, -32'sd1000, 32'sd0, 0, 0, '0));
      directed_plan.push_back(row(0, 0, 32'sd0, 32'sd1000, 1, 0, '0));
      // widest threshold: offset equal to it is still near
      directed_plan.push_back(row(1, THR_MAX, 32'sd0, 32'sd0, 0, 0, '0));
      directed_plan.push_back(row(0, 0, CMAX, 32'sd0, 0, 0, '0));
      directed_plan.push_back(row(0, 0, CMIN, 32'sd5, 1, 0, '0));
      // threshold narrowed mid-line: degenerate keeps the per-arrival view
      directed_plan.push_back(row(1, 31'd100, 32'sd0, 32'sd0, 0, 0, '0));
      directed_plan.push_back(row(0, 0, 32'sd50, 32'sd50, 0, 0, '0));
      directed_plan.push_back(row(1, 31'd10, 32'sd5, 32'sd5, 1, 0, '0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         p = directed_plan[i];
         if (p.set_thr) write_threshold(p.thr);
         send_vertex(p.vtx, p.typed, p.want);
      end

      small_items = 0;
      line_no     = 0;
      phase       = 0;
      over_done   = 1'b0;
      idle_on     = 1'b1;
      while (small_items < SMALL_ITEMS) begin
         if (line_no % 25 == 0) begin
            write_threshold(pick_threshold(phase));
            phase++;
            idle_on = small_items < CALM_FROM && $urandom_range(0, 2) != 0;
         end
         if (!over_done && small_items > 200) begin
            // store filled and overrun, closing flag lands on a dropped vertex
            write_threshold(31'($urandom_range(0, 4096)));
            len = STORE_DEPTH + $urandom_range(1, 4);
            send_line(len, 1'b1, 1'b0);
            small_items += len;
            over_done = 1'b1;
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: len = $urandom_range(1, 3);
            5, 6, 7:       len = $urandom_range(13, 40);
            default:       len = $urandom_range(4, 12);
         endcase
         if (small_items >= CALM_FROM) idle_on = 1'b0;
         send_line(len, 1'b0, idle_on);
         if (idle_on && $urandom_range(0, 2) == 0) go_idle($urandom_range(1, 8));
         small_items += len;
         line_no++;
      end

      go_idle(1);
      while (expected_directions.size() != 0) @(negedge clock);
      repeat (2 * STORE_DEPTH + 100) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
